[rtl/cyk_pkg.sv]
// Package: field widths, item kind codes and status flag positions for the CYK recognizer.
package cyk_pkg;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned NT_W   = 5;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 6;
	localparam int unsigned ROOT_W = 32;
	localparam int unsigned STAT_W = 2;

	localparam logic [NT_W-1:0] START_RESET = NT_W'(8'd83 - 8'd65);

	typedef enum logic [KIND_W-1:0] {
		KIND_BIN   = 2'd0,
		KIND_TERM  = 2'd1,
		KIND_SYM   = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	localparam int unsigned FLAG_TRUNC = 0;
	localparam int unsigned FLAG_RULES = 1;

	typedef struct packed {
		logic [NT_W-1:0] head;
		logic [NT_W-1:0] left;
		logic [NT_W-1:0] right;
	} bin_rule_t;

	typedef struct packed {
		logic [NT_W-1:0]   head;
		logic [BYTE_W-1:0] sym;
	} term_rule_t;
endpackage

[rtl/cyk_if.sv]
// Interfaces: item, result and configuration channels of the CYK recognizer.
interface cyk_item_if;
	logic                        valid;
	logic                        ready;
	cyk_pkg::kind_t              kind;
	logic [cyk_pkg::NT_W-1:0]    head;
	logic [cyk_pkg::NT_W-1:0]    first_child;
	logic [cyk_pkg::NT_W-1:0]    second_child;
	logic [cyk_pkg::BYTE_W-1:0]  terminal;
	logic                        last;
	modport source (output valid, kind, head, first_child, second_child, terminal, last,
		input ready);
	modport sink (input valid, kind, head, first_child, second_child, terminal, last,
		output ready);
endinterface

interface cyk_result_if;
	logic                        valid;
	logic                        ready;
	logic                        member;
	logic [cyk_pkg::LEN_W-1:0]   length;
	logic [cyk_pkg::ROOT_W-1:0]  root_set;
	logic [cyk_pkg::STAT_W-1:0]  status;
	modport source (output valid, member, length, root_set, status, input ready);
	modport sink (input valid, member, length, root_set, status, output ready);
endinterface

interface cyk_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [cyk_pkg::NT_W-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/cyk_span_ram.sv]
// Span table memory: one write port, two registered read ports.
module cyk_span_ram #(
	parameter int unsigned DEPTH = 528,
	parameter int unsigned WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [WIDTH-1:0]           rdata_a,
	output logic [WIDTH-1:0]           rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

[rtl/cyk_cnf_recognizer_unit.sv]
// Top level: CYK recognizer with rule stores, symbol buffer and a sequenced table fill.
//
//  channel | role | beat
//  item    | sink | rule load, grammar clear or string symbol
//  result  | src  | member, length, root set, status per parsed string
//  cfg     | sink | start symbol write
//
// Rule loads, clears and non-final symbols are each handled in the idle state.
// The final symbol starts the fill: each length-one cell reads its symbol and scans the terminal
// rules, then each longer cell walks its splits, reading both halves and scanning the binary
// rules only for a split whose halves are both non-empty, all rules through the one rule-read
// port; the root cell is then read and the result closes out.
// Reset clears counts and flags and sets the start symbol to S; the stores hold garbage until written.
// item is not ready during a fill; the fill holds at its end until the result slot is free.
module cyk_cnf_recognizer_unit #(
	parameter int unsigned MAX_LEN      = 32,
	parameter int unsigned NONTERMINALS = 32,
	parameter int unsigned MAX_RULES    = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	cyk_item_if.sink     item,
	cyk_result_if.source result,
	cyk_cfg_if.sink      cfg
);
	import cyk_pkg::*;

	localparam int unsigned LW  = $clog2(MAX_LEN + 1);
	localparam int unsigned IW  = $clog2(MAX_LEN);
	localparam int unsigned RCW = $clog2(MAX_RULES + 1);
	localparam int unsigned RIW = $clog2(MAX_RULES);
	localparam int unsigned SD  = MAX_LEN * (MAX_LEN + 1) / 2;
	localparam int unsigned SAW = $clog2(SD);

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_T_SYM   = 10'b0000000010,
		ST_T_RULE  = 10'b0000000100,
		ST_B_CELL  = 10'b0000001000,
		ST_B_SPLIT = 10'b0000010000,
		ST_B_PAIR  = 10'b0000100000,
		ST_B_RULE  = 10'b0001000000,
		ST_B_NEXT  = 10'b0010000000,
		ST_R_ISSUE = 10'b0100000000,
		ST_R_WAIT  = 10'b1000000000
	} state_t;

	typedef logic [NONTERMINALS-1:0] set_t;

	function automatic set_t nt_bit(input logic [NT_W-1:0] x);
		set_t b;
		b = '0;
		if (32'(x) < NONTERMINALS) begin
			b = set_t'(1) << x;
		end
		return b;
	endfunction

	state_t            state_q;
	logic [NT_W-1:0]   start_q;
	logic [RCW-1:0]    bcnt_q, tcnt_q, ri_q;
	logic [LW-1:0]     scnt_q, n_q, len_q;
	logic [1:0]        flags_q;
	logic [IW-1:0]     st_q, sp_q, ls_row_q, rs_row_q;
	logic [SAW-1:0]    ls_base_q, rs_base_q, prev_base_q, cur_base_q;
	logic              pend_q;
	set_t              acc_q;

	bin_rule_t         bin_mem [MAX_RULES];
	term_rule_t        term_mem [MAX_RULES];
	logic [BYTE_W-1:0] sym_mem [MAX_LEN];
	bin_rule_t         bin_rd_q;
	term_rule_t        term_rd_q;
	logic [BYTE_W-1:0] sym_rd_q;

	logic              res_valid_q, res_member_q;
	logic [LEN_W-1:0]  res_len_q;
	logic [ROOT_W-1:0] res_root_q;
	logic [STAT_W-1:0] res_stat_q;

	logic              span_we, span_re;
	logic [SAW-1:0]    span_waddr, span_ra, span_rb;
	set_t              span_da, span_db;

	logic item_acc, bin_wr, term_wr, sym_wr, rule_more, slot_free;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_acc   = item.valid && item.ready;
	assign bin_wr     = item_acc && item.kind == KIND_BIN && bcnt_q < RCW'(MAX_RULES);
	assign term_wr    = item_acc && item.kind == KIND_TERM && tcnt_q < RCW'(MAX_RULES);
	assign sym_wr     = item_acc && item.kind == KIND_SYM && scnt_q < LW'(MAX_LEN);
	assign rule_more  = (state_q == ST_T_RULE) ? (ri_q < tcnt_q) : (ri_q < bcnt_q);
	assign slot_free  = !res_valid_q || result.ready;

	assign result.valid    = res_valid_q;
	assign result.member   = res_member_q;
	assign result.length   = res_len_q;
	assign result.root_set = res_root_q;
	assign result.status   = res_stat_q;

	always_comb begin
		span_we    = 1'b0;
		span_waddr = cur_base_q + SAW'(st_q);
		span_re    = 1'b0;
		span_ra    = ls_base_q + SAW'(st_q);
		span_rb    = rs_base_q + SAW'(st_q) + SAW'(sp_q);
		case (state_q)
			ST_T_RULE: begin
				span_we    = !rule_more && !pend_q;
				span_waddr = SAW'(st_q);
			end
			ST_B_NEXT: span_we = (LW'(sp_q) == len_q - LW'(1));
			ST_B_SPLIT: span_re = 1'b1;
			ST_R_ISSUE: begin
				span_re = 1'b1;
				span_ra = cur_base_q;
			end
			default: ;
		endcase
	end

	cyk_span_ram #(.DEPTH(SD), .WIDTH(NONTERMINALS)) u_span (
		.clk     (clk),
		.we      (span_we),
		.waddr   (span_waddr),
		.wdata   (acc_q),
		.re      (span_re),
		.raddr_a (span_ra),
		.raddr_b (span_rb),
		.rdata_a (span_da),
		.rdata_b (span_db)
	);

	always_ff @(posedge clk) begin
		if (bin_wr) begin
			bin_mem[bcnt_q[RIW-1:0]] <= '{head: item.head, left: item.first_child,
				right: item.second_child};
		end
		if (term_wr) begin
			term_mem[tcnt_q[RIW-1:0]] <= '{head: item.head, sym: item.terminal};
		end
		if (sym_wr) begin
			sym_mem[scnt_q[IW-1:0]] <= item.terminal;
		end
		if (state_q == ST_T_SYM) begin
			sym_rd_q <= sym_mem[st_q];
		end
		if (state_q == ST_T_RULE && rule_more) begin
			term_rd_q <= term_mem[ri_q[RIW-1:0]];
		end
		if (state_q == ST_B_RULE && rule_more) begin
			bin_rd_q <= bin_mem[ri_q[RIW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_R_WAIT && slot_free) begin
			res_member_q <= (span_da & nt_bit(start_q)) != '0;
			res_len_q    <= LEN_W'(n_q);
			res_root_q   <= ROOT_W'(span_da);
			res_stat_q   <= flags_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= START_RESET;
			bcnt_q      <= '0;
			tcnt_q      <= '0;
			scnt_q      <= '0;
			flags_q     <= '0;
			res_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			ri_q        <= '0;
			n_q         <= '0;
			len_q       <= '0;
			st_q        <= '0;
			sp_q        <= '0;
			ls_row_q    <= '0;
			rs_row_q    <= '0;
			ls_base_q   <= '0;
			rs_base_q   <= '0;
			prev_base_q <= '0;
			cur_base_q  <= '0;
			acc_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				start_q <= cfg.data;
			end
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						case (item.kind)
							KIND_BIN: begin
								if (bin_wr) bcnt_q <= bcnt_q + RCW'(1);
								else flags_q[FLAG_RULES] <= 1'b1;
							end
							KIND_TERM: begin
								if (term_wr) tcnt_q <= tcnt_q + RCW'(1);
								else flags_q[FLAG_RULES] <= 1'b1;
							end
							KIND_CLEAR: begin
								bcnt_q <= '0;
								tcnt_q <= '0;
								flags_q[FLAG_RULES] <= 1'b0;
							end
							default: begin
								if (sym_wr) scnt_q <= scnt_q + LW'(1);
								else flags_q[FLAG_TRUNC] <= 1'b1;
								if (item.last) begin
									n_q     <= sym_wr ? scnt_q + LW'(1) : scnt_q;
									st_q    <= '0;
									state_q <= ST_T_SYM;
								end
							end
						endcase
					end
				end
				ST_T_SYM: begin
					acc_q   <= '0;
					ri_q    <= '0;
					state_q <= ST_T_RULE;
				end
				ST_T_RULE: begin
					if (pend_q && term_rd_q.sym == sym_rd_q) begin
						acc_q <= acc_q | nt_bit(term_rd_q.head);
					end
					if (rule_more) begin
						ri_q   <= ri_q + RCW'(1);
						pend_q <= 1'b1;
					end else if (!pend_q) begin
						if (LW'(st_q) == n_q - LW'(1)) begin
							cur_base_q <= '0;
							if (n_q == LW'(1)) begin
								state_q <= ST_R_ISSUE;
							end else begin
								len_q       <= LW'(2);
								prev_base_q <= '0;
								cur_base_q  <= SAW'(MAX_LEN);
								st_q        <= '0;
								state_q     <= ST_B_CELL;
							end
						end else begin
							st_q    <= st_q + IW'(1);
							state_q <= ST_T_SYM;
						end
					end
				end
				ST_B_CELL: begin
					acc_q     <= '0;
					sp_q      <= IW'(1);
					ls_row_q  <= '0;
					ls_base_q <= '0;
					rs_row_q  <= IW'(len_q - LW'(2));
					rs_base_q <= prev_base_q;
					state_q   <= ST_B_SPLIT;
				end
				ST_B_SPLIT: state_q <= ST_B_PAIR;
				ST_B_PAIR: begin
					ri_q <= '0;
					if (span_da == '0 || span_db == '0) state_q <= ST_B_NEXT;
					else state_q <= ST_B_RULE;
				end
				ST_B_RULE: begin
					if (pend_q && (span_da & nt_bit(bin_rd_q.left)) != '0
						&& (span_db & nt_bit(bin_rd_q.right)) != '0) begin
						acc_q <= acc_q | nt_bit(bin_rd_q.head);
					end
					if (rule_more) begin
						ri_q   <= ri_q + RCW'(1);
						pend_q <= 1'b1;
					end else if (!pend_q) begin
						state_q <= ST_B_NEXT;
					end
				end
				ST_B_NEXT: begin
					if (LW'(sp_q) == len_q - LW'(1)) begin
						if (LW'(st_q) == n_q - len_q) begin
							if (len_q == n_q) begin
								state_q <= ST_R_ISSUE;
							end else begin
								len_q       <= len_q + LW'(1);
								prev_base_q <= cur_base_q;
								cur_base_q  <= cur_base_q + SAW'(MAX_LEN + 1) - SAW'(len_q);
								st_q        <= '0;
								state_q     <= ST_B_CELL;
							end
						end else begin
							st_q    <= st_q + IW'(1);
							state_q <= ST_B_CELL;
						end
					end else begin
						sp_q      <= sp_q + IW'(1);
						ls_base_q <= ls_base_q + SAW'(MAX_LEN) - SAW'(ls_row_q);
						ls_row_q  <= ls_row_q + IW'(1);
						rs_base_q <= rs_base_q - SAW'(MAX_LEN + 1) + SAW'(rs_row_q);
						rs_row_q  <= rs_row_q - IW'(1);
						state_q   <= ST_B_SPLIT;
					end
				end
				ST_R_ISSUE: state_q <= ST_R_WAIT;
				ST_R_WAIT: begin
					if (slot_free) begin
						res_valid_q         <= 1'b1;
						scnt_q              <= '0;
						flags_q[FLAG_TRUNC] <= 1'b0;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
